>>> rtl/fct_pkg.sv
// Package: shared types, codes and helpers of the frustum culling engine.
package fct_pkg;

    localparam int ACC_W = 68;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_POINT  = 2'd1,
        OP_SPHERE = 2'd2,
        OP_CUBE   = 2'd3
    } op_t;

    typedef struct packed {
        logic                    valid;
        op_t                     op;
        logic [2:0]              pidx;
        logic signed [31:0]      a;
        logic signed [31:0]      b;
        logic signed [31:0]      c;
        logic signed [31:0]      d;
        logic signed [31:0]      x;
        logic signed [31:0]      y;
        logic signed [31:0]      z;
        logic [30:0]             e;
        logic                    in_view;
        logic signed [ACC_W-1:0] ssum;
    } item_t;

    // magnitude of a signed 32-bit value
    function automatic logic [32:0] abs32(input logic signed [31:0] v);
        logic [32:0] w;
        begin
            w = {v[31], v};
            abs32 = v[31] ? (33'd0 - w) : w;
        end
    endfunction

endpackage

>>> rtl/fct_if.sv
// Interfaces: request and response channels of the frustum culling engine.
interface fct_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [2:0]        plane_index;
    logic signed [31:0] plane_a;
    logic signed [31:0] plane_b;
    logic signed [31:0] plane_c;
    logic signed [31:0] plane_d;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]       extent;

    modport source (output valid, opcode, plane_index, plane_a, plane_b, plane_c, plane_d,
                    pos_x, pos_y, pos_z, extent, input ready);
    modport sink   (input valid, opcode, plane_index, plane_a, plane_b, plane_c, plane_d,
                    pos_x, pos_y, pos_z, extent, output ready);
endinterface

interface fct_rsp_if;
    logic              valid;
    logic              ready;
    logic              inside_res;
    logic signed [31:0] sphere_depth;

    modport source (output valid, inside_res, sphere_depth, input ready);
    modport sink   (input valid, inside_res, sphere_depth, output ready);
endinterface

>>> rtl/fct_cell.sv
// Cell: holds one plane and tests each passing item against it in two stages.
module fct_cell #(
    parameter int INDEX     = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  fct_pkg::item_t up,
    output fct_pkg::item_t down
);
    import fct_pkg::*;

    logic signed [31:0]      pa_reg, pb_reg, pc_reg, pd_reg;
    logic [33:0]             abs_reg;
    item_t                   st_reg;
    logic signed [63:0]      pax_reg, pby_reg, pcz_reg;
    logic [64:0]             cube_reg;
    logic signed [ACC_W-1:0] dsh_reg;
    item_t                   down_reg;
    item_t                   down_next;

    logic signed [ACC_W-1:0] dc, val, esh;
    logic                    load_hit;

    assign load_hit = up.valid && (up.op == OP_LOAD) && (up.pidx == 3'(INDEX));

    // stage one: plane store, products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_reg  <= '0;
            pb_reg  <= '0;
            pc_reg  <= '0;
            pd_reg  <= '0;
            abs_reg <= '0;
            st_reg  <= '0;
        end
        else if (en)
        begin
            st_reg <= up;
            if (load_hit)
            begin
                pa_reg  <= up.a;
                pb_reg  <= up.b;
                pc_reg  <= up.c;
                pd_reg  <= up.d;
                abs_reg <= 34'(abs32(up.a)) + 34'(abs32(up.b)) + 34'(abs32(up.c));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pax_reg  <= 64'(pa_reg) * 64'(up.x);
            pby_reg  <= 64'(pb_reg) * 64'(up.y);
            pcz_reg  <= 64'(pc_reg) * 64'(up.z);
            cube_reg <= 65'(up.e) * 65'(abs_reg);
            dsh_reg  <= ACC_W'(pd_reg) <<< FRAC_BITS;
        end
    end

    // stage two: sum and compare; the best cube corner adds e*(|a|+|b|+|c|)
    always_comb
    begin
        dc  = ACC_W'(pax_reg) + ACC_W'(pby_reg) + ACC_W'(pcz_reg) + dsh_reg;
        esh = $signed(ACC_W'(st_reg.e) << FRAC_BITS);
        unique case (st_reg.op)
            OP_SPHERE: val = dc + esh;
            OP_CUBE:   val = dc + $signed(ACC_W'(cube_reg));
            default:   val = dc;
        endcase
        down_next = st_reg;
        if (st_reg.op != OP_LOAD)
        begin
            down_next.in_view = st_reg.in_view && (val > 0);
            down_next.ssum    = val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            down_reg <= '0;
        else if (en)
            down_reg <= down_next;
    end

    assign down = down_reg;

endmodule

>>> rtl/frustum_cull_test_top.sv
// Top level: six-plane frustum culling engine built as a chain of plane cells.
//
// Usage:
//   req carries one beat per item: opcode 0 loads plane plane_index with
//   plane_a..plane_d, opcodes 1, 2, 3 test a point, sphere or cube at
//   pos_x/y/z with extent as radius or half-size. Loads give no response.
//   rsp carries one beat per test: inside_res, and sphere_depth for a
//   passing sphere (last plane distance plus radius, saturated), else 0.
// Timing:
//   Each cell registers its products, then its sum and compare, and the
//   response register follows. One beat enters every cycle while req.ready
//   is high; loads travel the same chain, so tests see planes in issue
//   order.
// Reset:
//   All planes clear to zero and the chain empties.
// Stall:
//   When the response register holds a beat that rsp does not take, the
//   whole chain and req.ready hold until it is taken.
module frustum_cull_test_top #(
    parameter int PLANE_COUNT = 6,
    parameter int FRAC_BITS   = 16
) (
    input logic  clk,
    input logic  rst_n,
    fct_req_if.sink   req,
    fct_rsp_if.source rsp
);
    import fct_pkg::*;

    item_t chain [PLANE_COUNT+1];
    item_t last;
    logic  en;

    logic                    valid_reg, valid_next;
    logic                    inside_reg, inside_next;
    logic signed [31:0]      depth_reg, depth_next;
    logic signed [ACC_W-1:0] sh;

    // advance whenever the response slot is free or drains this cycle
    assign en        = !valid_reg || rsp.ready;
    assign req.ready = en;

    always_comb
    begin
        chain[0]         = '0;
        chain[0].valid   = req.valid;
        chain[0].op      = op_t'(req.opcode);
        chain[0].pidx    = req.plane_index;
        chain[0].a       = req.plane_a;
        chain[0].b       = req.plane_b;
        chain[0].c       = req.plane_c;
        chain[0].d       = req.plane_d;
        chain[0].x       = req.pos_x;
        chain[0].y       = req.pos_y;
        chain[0].z       = req.pos_z;
        chain[0].e       = req.extent;
        chain[0].in_view = 1'b1;
    end

    for (genvar i = 0; i < PLANE_COUNT; i++)
    begin : g_cell
        fct_cell #(.INDEX(i), .FRAC_BITS(FRAC_BITS)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .up   (chain[i]),
            .down (chain[i+1])
        );
    end

    assign last = chain[PLANE_COUNT];

    // response: drop loads, floor-shift and saturate the sphere depth
    always_comb
    begin
        sh          = last.ssum >>> FRAC_BITS;
        valid_next  = last.valid && (last.op != OP_LOAD);
        inside_next = last.in_view;
        depth_next  = '0;
        if (last.op == OP_SPHERE && last.in_view)
        begin
            if (sh > $signed(ACC_W'(32'h7FFF_FFFF)))
                depth_next = 32'sh7FFF_FFFF;
            else
                depth_next = sh[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_reg <= inside_next;
            depth_reg  <= depth_next;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.inside_res   = inside_reg;
    assign rsp.sphere_depth = depth_reg;

endmodule

>>> rtl/fct_checker.sv
// Checker: port-level assertions for the frustum culling engine, bound to the top.
module fct_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              rsp_inside,
    input logic signed [31:0] rsp_depth
);
    // request side stalls exactly when a response beat waits
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready == (!rsp_valid || rsp_ready))
        else $error("req.ready does not follow response backpressure");

    // a nonzero depth only comes from a passing sphere
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_depth != 0) |-> (rsp_inside && rsp_depth > 0))
        else $error("sphere_depth nonzero on a culled or negative result");

    // a stalled response beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_inside)
                                       && $stable(rsp_depth)))
        else $error("stalled response changed");

    // no response beat rises straight out of reset
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(rst_n))
        else $error("response raised straight out of reset");
endmodule

bind frustum_cull_test_top fct_checker u_fct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_inside(rsp.inside_res),
    .rsp_depth (rsp.sphere_depth)
);
